/* sv/hack_assembly_line_encoder_core_macros.svh */
// Assertion macros for the Hack assembly line encoder checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef HACK_ASSEMBLY_LINE_ENCODER_CORE_MACROS_SVH
`define HACK_ASSEMBLY_LINE_ENCODER_CORE_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define HALE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked while reset is asserted
`define HALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that is checked through reset as well
`define HALE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/hale_pkg.sv */
// Shared types, character codes and mnemonic tables for the Hack line encoder.
// Depends on nothing; imported by hale_step and the top level.
package hale_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR,
        PH_FIRST,
        PH_COMP,
        PH_JUMP
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [23:0] chars;
        logic [2:0]  len;
        logic [2:0]  dest;
        logic [6:0]  comp;
        logic        err;
    } tok_state_t;

    typedef struct packed {
        logic       hit;
        logic [6:0] code;
    } lookup_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] C_PREFIX  = 3'b111;
    localparam logic [2:0] PART_MAX  = 3'd3;
    localparam logic [2:0] COUNT_MAX = 3'd4;

    function automatic lookup_t comp_lookup(input logic [2:0] len, input logic [23:0] chars);
        lookup_t r;
        r.hit  = 1'b1;
        r.code = 7'h00;
        case ({len, chars})
            {3'd1, 16'h0, "0"}: r.code = 7'h2A;
            {3'd1, 16'h0, "1"}: r.code = 7'h3F;
            {3'd2, 8'h0, "-1"}: r.code = 7'h3A;
            {3'd1, 16'h0, "D"}: r.code = 7'h0C;
            {3'd1, 16'h0, "A"}: r.code = 7'h30;
            {3'd1, 16'h0, "M"}: r.code = 7'h70;
            {3'd2, 8'h0, "!D"}: r.code = 7'h0D;
            {3'd2, 8'h0, "!A"}: r.code = 7'h31;
            {3'd2, 8'h0, "!M"}: r.code = 7'h71;
            {3'd2, 8'h0, "-D"}: r.code = 7'h0F;
            {3'd2, 8'h0, "-A"}: r.code = 7'h33;
            {3'd2, 8'h0, "-M"}: r.code = 7'h73;
            {3'd3, "D+1"}:      r.code = 7'h1F;
            {3'd3, "A+1"}:      r.code = 7'h37;
            {3'd3, "M+1"}:      r.code = 7'h77;
            {3'd3, "D-1"}:      r.code = 7'h0E;
            {3'd3, "A-1"}:      r.code = 7'h32;
            {3'd3, "M-1"}:      r.code = 7'h72;
            {3'd3, "D+A"}:      r.code = 7'h02;
            {3'd3, "D+M"}:      r.code = 7'h42;
            {3'd3, "D-A"}:      r.code = 7'h13;
            {3'd3, "D-M"}:      r.code = 7'h53;
            {3'd3, "A-D"}:      r.code = 7'h07;
            {3'd3, "M-D"}:      r.code = 7'h47;
            {3'd3, "D&A"}:      r.code = 7'h00;
            {3'd3, "D&M"}:      r.code = 7'h40;
            {3'd3, "D|A"}:      r.code = 7'h15;
            {3'd3, "D|M"}:      r.code = 7'h55;
            default:            r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic lookup_t dest_lookup(input logic [2:0] len, input logic [23:0] chars);
        lookup_t r;
        r.hit  = 1'b1;
        r.code = 7'h00;
        case ({len, chars})
            {3'd1, 16'h0, "M"}: r.code = 7'd1;
            {3'd1, 16'h0, "D"}: r.code = 7'd2;
            {3'd2, 8'h0, "MD"}: r.code = 7'd3;
            {3'd1, 16'h0, "A"}: r.code = 7'd4;
            {3'd2, 8'h0, "AM"}: r.code = 7'd5;
            {3'd2, 8'h0, "AD"}: r.code = 7'd6;
            {3'd3, "AMD"}:      r.code = 7'd7;
            default:            r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic lookup_t jump_lookup(input logic [2:0] len, input logic [23:0] chars);
        lookup_t r;
        r.hit  = 1'b1;
        r.code = 7'h00;
        case ({len, chars})
            {3'd3, "JGT"}: r.code = 7'd1;
            {3'd3, "JEQ"}: r.code = 7'd2;
            {3'd3, "JGE"}: r.code = 7'd3;
            {3'd3, "JLT"}: r.code = 7'd4;
            {3'd3, "JNE"}: r.code = 7'd5;
            {3'd3, "JLE"}: r.code = 7'd6;
            {3'd3, "JMP"}: r.code = 7'd7;
            default:       r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* sv/hale_step.sv */
// Per-beat token update: next token state, address accumulation and word packing.
// Depends on hale_pkg (state struct, character codes, mnemonic tables).
module hale_step
    import hale_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  tok_state_t           cur_state,
    input  logic [WORD_BITS-1:0] cur_acc,
    input  logic [7:0]           text_byte,
    output tok_state_t           nxt_state,
    output logic [WORD_BITS-1:0] nxt_acc,
    output logic                 fire,
    output logic [WORD_BITS-1:0] word,
    output logic                 bad
);

    localparam int ACC_W = WORD_BITS + 4;
    localparam logic [ACC_W-1:0] ADDR_MAX = ACC_W'((1 << (WORD_BITS - 1)) - 1);
    localparam logic [WORD_BITS-1:0] ADDR_SAT = WORD_BITS'(ADDR_MAX + ACC_W'(1));

    tok_state_t           base;
    logic [WORD_BITS-1:0] base_acc;
    logic                 is_ws;
    logic                 is_digit;
    logic                 err;
    logic [2:0]           dest_f;
    logic [6:0]           comp_f;
    logic [2:0]           jump_f;
    lookup_t              lk;
    logic [ACC_W-1:0]     prod;

    assign is_ws = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                   (text_byte == CH_CR) || (text_byte == CH_LF);
    assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign prod = (ACC_W'(base_acc) << 3) + (ACC_W'(base_acc) << 1) +
                  ACC_W'(text_byte - CH_ZERO);

    always_comb begin
        base     = cur_state;
        base_acc = cur_acc;
        if (cur_state.phase == PH_IDLE) begin
            base       = '0;
            base.phase = PH_FIRST;
            base_acc   = '0;
        end

        nxt_state = cur_state;
        nxt_acc   = cur_acc;
        fire      = 1'b0;
        word      = '0;
        bad       = 1'b0;
        err       = cur_state.err;
        dest_f    = cur_state.dest;
        comp_f    = cur_state.comp;
        jump_f    = 3'd0;
        lk        = '0;

        if (is_ws) begin
            if (cur_state.phase != PH_IDLE) begin
                fire = 1'b1;
                case (cur_state.phase)
                    PH_ADDR: begin
                        if (cur_state.len == 3'd0) begin
                            err = 1'b1;
                        end
                        word = cur_acc;
                    end
                    PH_JUMP: begin
                        lk     = jump_lookup(cur_state.len, cur_state.chars);
                        jump_f = lk.code[2:0];
                        err    = err | ~lk.hit;
                        word   = WORD_BITS'({C_PREFIX, comp_f, dest_f, jump_f});
                    end
                    default: begin
                        if (cur_state.phase == PH_FIRST) begin
                            dest_f = 3'd0;
                        end
                        lk     = comp_lookup(cur_state.len, cur_state.chars);
                        comp_f = lk.code;
                        err    = err | ~lk.hit;
                        word   = WORD_BITS'({C_PREFIX, comp_f, dest_f, jump_f});
                    end
                endcase
                if (err) begin
                    word = '0;
                end
                bad       = err;
                nxt_state = '0;
                nxt_acc   = '0;
            end
        end else if (cur_state.phase == PH_IDLE && text_byte == CH_AT) begin
            nxt_state       = '0;
            nxt_state.phase = PH_ADDR;
            nxt_acc         = '0;
        end else begin
            nxt_state = base;
            nxt_acc   = base_acc;
            case (base.phase)
                PH_ADDR: begin
                    if (is_digit) begin
                        if (prod > ADDR_MAX) begin
                            nxt_state.err = 1'b1;
                            nxt_acc       = ADDR_SAT;
                        end else begin
                            nxt_acc = WORD_BITS'(prod);
                        end
                        if (base.len < COUNT_MAX) begin
                            nxt_state.len = base.len + 3'd1;
                        end
                    end else begin
                        nxt_state.err = 1'b1;
                    end
                end
                default: begin
                    if (text_byte == CH_EQ) begin
                        if (base.phase == PH_FIRST) begin
                            lk              = dest_lookup(base.len, base.chars);
                            nxt_state.dest  = lk.code[2:0];
                            nxt_state.err   = base.err | ~lk.hit;
                            nxt_state.phase = PH_COMP;
                        end else begin
                            nxt_state.err = 1'b1;
                        end
                        nxt_state.chars = '0;
                        nxt_state.len   = '0;
                    end else if (text_byte == CH_SEMI) begin
                        if (base.phase == PH_JUMP) begin
                            nxt_state.err = 1'b1;
                        end else begin
                            lk              = comp_lookup(base.len, base.chars);
                            nxt_state.comp  = lk.code;
                            nxt_state.err   = base.err | ~lk.hit;
                            nxt_state.phase = PH_JUMP;
                        end
                        nxt_state.chars = '0;
                        nxt_state.len   = '0;
                    end else begin
                        if (base.len < PART_MAX) begin
                            nxt_state.chars = {base.chars[15:0], text_byte};
                        end
                        if (base.len < COUNT_MAX) begin
                            nxt_state.len = base.len + 3'd1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

/* sv/hack_assembly_line_encoder_core.sv */
// Hack assembly line encoder: one text byte per beat, one machine word per token.
// The result is registered: it appears in the cycle after the whitespace beat that ends a token.
// Throughput: one byte per cycle while the result register is not stalled; the token state update is combinational.
// The result register decouples the sides: a byte is taken whenever it is empty or drained.
// Reset (aresetn low, synchronous) returns to idle between tokens and drops any pending result.
module hack_assembly_line_encoder_core
    import hale_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_BITS-1:0] m_machine_word,
    output logic                 m_bad_token
);

    tok_state_t           state_reg;
    tok_state_t           state_next;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] acc_next;
    logic                 m_valid_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 bad_reg;
    logic                 bad_next;
    logic                 fire;
    logic                 accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    hale_step #(
        .WORD_BITS (WORD_BITS)
    ) u_step (
        .cur_state (state_reg),
        .cur_acc   (acc_reg),
        .text_byte (s_text_byte),
        .nxt_state (state_next),
        .nxt_acc   (acc_next),
        .fire      (fire),
        .word      (word_next),
        .bad       (bad_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                acc_reg     <= acc_next;
                m_valid_reg <= fire;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && fire) begin
            word_reg <= word_next;
            bad_reg  <= bad_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_machine_word = word_reg;
    assign m_bad_token    = bad_reg;

endmodule

/* sv/hale_checker.sv */
// Port-level checker for the Hack assembly line encoder, bound to the top level.
// Depends on hack_assembly_line_encoder_core_macros.svh.
`include "hack_assembly_line_encoder_core_macros.svh"

module hale_checker #(
    parameter int WORD_BITS = 16
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [7:0]           s_text_byte,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [WORD_BITS-1:0] m_machine_word,
    input logic                 m_bad_token
);

    `HALE_ASSERT_NEXT_ALWAYS(a_reset_drops_result, aclk, !aresetn, !m_valid)
    `HALE_ASSERT_IMPLY(a_bad_word_zero, aclk, aresetn, m_valid && m_bad_token, m_machine_word == '0)
    `HALE_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `HALE_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_machine_word) && $stable(m_bad_token))
    `HALE_ASSERT_NEXT(a_input_holds, aclk, aresetn, s_valid && !s_ready,
        s_valid && $stable(s_text_byte))

endmodule

bind hack_assembly_line_encoder_core hale_checker #(
    .WORD_BITS (WORD_BITS)
) u_hale_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_text_byte    (s_text_byte),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_machine_word (m_machine_word),
    .m_bad_token    (m_bad_token)
);
